FILE: rtl/spherical_to_cartesian_macros.svh
// Assertion macros for the spherical-to-Cartesian converter.
// Used by rtl/spherical_to_cartesian.sv; they expect clk and arst_n in scope.
`ifndef SPHERICAL_TO_CARTESIAN_MACROS_SVH
`define SPHERICAL_TO_CARTESIAN_MACROS_SVH

`ifndef SYNTH

// A property that must hold at every clock edge outside reset.
`define S2C_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("spherical_to_cartesian: assertion failed");

// A condition in one cycle that implies another in the next cycle.
`define S2C_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("spherical_to_cartesian: assertion failed");

`else

`define S2C_ASSERT(lbl, prop)
`define S2C_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

FILE: rtl/s2c_pkg.sv
// Constants, types and datapath functions of the spherical-to-Cartesian converter.
// Standalone package; used by rtl/spherical_to_cartesian.sv.
`default_nettype none

package s2c_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int NSTG          = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
	localparam int SHW           = $clog2(TABLE_LEN);

	localparam int RAD_W = 16;
	localparam int ANG_W = 17;
	localparam int OUT_W = 17;
	localparam int CW    = 32;
	localparam int PW    = 2 * CW;
	localparam int RPW   = RAD_W + CW;
	localparam int FB    = 30;
	localparam int ZSH   = 16;
	localparam int RW    = ANG_W + 1;

	localparam logic signed [RW-1:0] ANG_TURN    = 18'sd46080;
	localparam logic signed [RW-1:0] ANG_HALF    = 18'sd23040;
	localparam logic signed [RW-1:0] ANG_QUARTER = 18'sd11520;

	localparam logic signed [CW-1:0] GAIN = 32'sd652032874;

	localparam logic signed [PW-1:0]  HALF_P  = 64'sd1 <<< (FB - 1);
	localparam logic signed [RPW-1:0] HALF_R  = 48'sd1 <<< (FB - 1);

	localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sd32768;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -17'sd32768;
	localparam logic signed [RPW-FB-1:0] SAT_MAX = 18'sd32768;
	localparam logic signed [RPW-FB-1:0] SAT_MIN = -18'sd32768;

	localparam logic signed [CW-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'sd377487360, 32'sd222843801, 32'sd117744544, 32'sd59768969,
		32'sd30000467,  32'sd15014858,  32'sd7509261,   32'sd3754860,
		32'sd1877459,   32'sd938733,    32'sd469367,    32'sd234683,
		32'sd117342,    32'sd58671,     32'sd29335,     32'sd14668,
		32'sd7334,      32'sd3667,      32'sd1833,      32'sd917,
		32'sd458,       32'sd229,       32'sd115,       32'sd57
	};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} s2c_lane_t;

	typedef struct packed {
		logic      neg;
		s2c_lane_t lane;
	} s2c_start_t;

	typedef struct packed {
		logic signed [RAD_W-1:0] radius;
		logic                    neg_inc;
		logic                    neg_azi;
		s2c_lane_t               inc;
		s2c_lane_t               azi;
	} s2c_cor_t;

	// Reduce an angle to one turn, fold it into the right half plane and
	// build the CORDIC start vector.
	function automatic s2c_start_t start_lane(input logic signed [ANG_W-1:0] ang);
		logic signed [RW-1:0] a;
		logic signed [RW-1:0] r;
		logic signed [RW-1:0] q;
		s2c_start_t res;
		a = {ang[ANG_W-1], ang};
		if (a > ANG_HALF) begin
			r = a - ANG_TURN;
		end else if (a <= -ANG_HALF) begin
			r = a + ANG_TURN;
		end else begin
			r = a;
		end
		res.neg = 1'b0;
		if (r > ANG_QUARTER) begin
			q = r - ANG_HALF;
			res.neg = 1'b1;
		end else if (r < -ANG_QUARTER) begin
			q = r + ANG_HALF;
			res.neg = 1'b1;
		end else begin
			q = r;
		end
		res.lane.x = GAIN;
		res.lane.y = '0;
		res.lane.z = {q[CW-ZSH-1:0], {ZSH{1'b0}}};
		return res;
	endfunction

	function automatic s2c_lane_t rot_step(input s2c_lane_t a, input logic [SHW-1:0] sh);
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		s2c_lane_t r;
		dx = a.y >>> sh;
		dy = a.x >>> sh;
		if (!a.z[CW-1]) begin
			r.x = a.x - dx;
			r.y = a.y + dy;
			r.z = a.z - ATAN_TAB[sh];
		end else begin
			r.x = a.x + dx;
			r.y = a.y - dy;
			r.z = a.z + ATAN_TAB[sh];
		end
		return r;
	endfunction

	// Q60 to Q30, to nearest with ties away from zero.
	function automatic logic signed [CW-1:0] round_q60(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		t = v + (v[PW-1] ? (HALF_P - 64'sd1) : HALF_P);
		return t[FB+CW-1:FB];
	endfunction

	// Q30 product to an integer, rounded as above and saturated.
	function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [RPW-1:0] v);
		logic signed [RPW-1:0]    t;
		logic signed [RPW-FB-1:0] q;
		logic signed [OUT_W-1:0]  r;
		t = v + (v[RPW-1] ? (HALF_R - 48'sd1) : HALF_R);
		q = t[RPW-1:FB];
		if (q > SAT_MAX) begin
			r = OUT_MAX;
		end else if (q < SAT_MIN) begin
			r = OUT_MIN;
		end else begin
			r = q[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/spherical_to_cartesian.sv
// Spherical-to-Cartesian converter: pipelined CORDIC sine and cosine, products, rounding.
// Depends on rtl/s2c_pkg.sv and rtl/spherical_to_cartesian_macros.svh.
`default_nettype none

// Converts a word of radius, inclination and azimuth (angles in 1/128 degree,
// any 17-bit value taken modulo a full turn) into x, y and z, each rounded to
// the nearest integer and saturated to plus or minus 32768. The datapath is a
// pipeline of CORDIC_STAGES rotation stages (at most 24) for both angles side
// by side, followed by a sign stage, two multiply stages and two rounding
// stages; a new word is accepted in every cycle while item_stall is low.
// The output register is backed by a one-word skid buffer; item_stall is
// high only while that buffer is full, and then the whole pipeline holds.
module spherical_to_cartesian (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire logic signed [s2c_pkg::RAD_W-1:0]     radius,
	input  wire logic signed [s2c_pkg::ANG_W-1:0]     incline,
	input  wire logic signed [s2c_pkg::ANG_W-1:0]     azimuth,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic signed [s2c_pkg::OUT_W-1:0]          x_out,
	output logic signed [s2c_pkg::OUT_W-1:0]          y_out,
	output logic signed [s2c_pkg::OUT_W-1:0]          z_out
);

	`include "spherical_to_cartesian_macros.svh"

	logic                          adv;
	s2c_pkg::s2c_start_t           st_inc;
	s2c_pkg::s2c_start_t           st_azi;

	logic [s2c_pkg::NSTG:0]        v_s2;
	s2c_pkg::s2c_cor_t             cor_s2 [0:s2c_pkg::NSTG];

	logic                          v_s3;
	logic signed [s2c_pkg::RAD_W-1:0] rad_s3;
	logic signed [s2c_pkg::CW-1:0] ci_s3;
	logic signed [s2c_pkg::CW-1:0] si_s3;
	logic signed [s2c_pkg::CW-1:0] ca_s3;
	logic signed [s2c_pkg::CW-1:0] sa_s3;

	logic                          v_s4;
	logic signed [s2c_pkg::RAD_W-1:0] rad_s4;
	logic signed [s2c_pkg::PW-1:0] pcc_s4;
	logic signed [s2c_pkg::PW-1:0] pcs_s4;
	logic signed [s2c_pkg::CW-1:0] si_s4;

	logic                          v_s5;
	logic signed [s2c_pkg::RAD_W-1:0] rad_s5;
	logic signed [s2c_pkg::CW-1:0] fx_s5;
	logic signed [s2c_pkg::CW-1:0] fy_s5;
	logic signed [s2c_pkg::CW-1:0] si_s5;

	logic                          v_s6;
	logic signed [s2c_pkg::RPW-1:0] rx_s6;
	logic signed [s2c_pkg::RPW-1:0] ry_s6;
	logic signed [s2c_pkg::RPW-1:0] rz_s6;

	logic signed [s2c_pkg::OUT_W-1:0] nx;
	logic signed [s2c_pkg::OUT_W-1:0] ny;
	logic signed [s2c_pkg::OUT_W-1:0] nz;

	logic                          ov_q;
	logic                          skv_q;
	logic signed [s2c_pkg::OUT_W-1:0] x_q;
	logic signed [s2c_pkg::OUT_W-1:0] y_q;
	logic signed [s2c_pkg::OUT_W-1:0] z_q;
	logic signed [s2c_pkg::OUT_W-1:0] skx_q;
	logic signed [s2c_pkg::OUT_W-1:0] sky_q;
	logic signed [s2c_pkg::OUT_W-1:0] skz_q;
	logic                          o_take;

	assign adv        = !skv_q;
	assign item_stall = skv_q;
	assign o_take     = ov_q && !result_stall;

	assign st_inc = s2c_pkg::start_lane(incline);
	assign st_azi = s2c_pkg::start_lane(azimuth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= '0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s2 <= {v_s2[s2c_pkg::NSTG-1:0], item_valid};
			v_s3 <= v_s2[s2c_pkg::NSTG];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cor_s2[0].radius  <= radius;
			cor_s2[0].neg_inc <= st_inc.neg;
			cor_s2[0].neg_azi <= st_azi.neg;
			cor_s2[0].inc     <= st_inc.lane;
			cor_s2[0].azi     <= st_azi.lane;
		end
	end

	for (genvar k = 1; k <= s2c_pkg::NSTG; k++) begin : g_rot
		always_ff @(posedge clk) begin
			if (adv) begin
				cor_s2[k].radius  <= cor_s2[k-1].radius;
				cor_s2[k].neg_inc <= cor_s2[k-1].neg_inc;
				cor_s2[k].neg_azi <= cor_s2[k-1].neg_azi;
				cor_s2[k].inc     <= s2c_pkg::rot_step(cor_s2[k-1].inc,
					s2c_pkg::SHW'(k - 1));
				cor_s2[k].azi     <= s2c_pkg::rot_step(cor_s2[k-1].azi,
					s2c_pkg::SHW'(k - 1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3 <= cor_s2[s2c_pkg::NSTG].radius;
			ci_s3  <= cor_s2[s2c_pkg::NSTG].neg_inc ?
				-cor_s2[s2c_pkg::NSTG].inc.x : cor_s2[s2c_pkg::NSTG].inc.x;
			si_s3  <= cor_s2[s2c_pkg::NSTG].neg_inc ?
				-cor_s2[s2c_pkg::NSTG].inc.y : cor_s2[s2c_pkg::NSTG].inc.y;
			ca_s3  <= cor_s2[s2c_pkg::NSTG].neg_azi ?
				-cor_s2[s2c_pkg::NSTG].azi.x : cor_s2[s2c_pkg::NSTG].azi.x;
			sa_s3  <= cor_s2[s2c_pkg::NSTG].neg_azi ?
				-cor_s2[s2c_pkg::NSTG].azi.y : cor_s2[s2c_pkg::NSTG].azi.y;

			rad_s4 <= rad_s3;
			pcc_s4 <= ci_s3 * ca_s3;
			pcs_s4 <= ci_s3 * sa_s3;
			si_s4  <= si_s3;

			rad_s5 <= rad_s4;
			fx_s5  <= s2c_pkg::round_q60(pcc_s4);
			fy_s5  <= s2c_pkg::round_q60(pcs_s4);
			si_s5  <= si_s4;

			rx_s6  <= rad_s5 * fx_s5;
			ry_s6  <= rad_s5 * fy_s5;
			rz_s6  <= rad_s5 * si_s5;
		end
	end

	assign nx = s2c_pkg::round_sat(rx_s6);
	assign ny = s2c_pkg::round_sat(ry_s6);
	assign nz = s2c_pkg::round_sat(rz_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			skv_q <= 1'b0;
		end else if (skv_q) begin
			if (o_take) begin
				skv_q <= 1'b0;
			end
		end else if (!ov_q || o_take) begin
			ov_q <= v_s6;
		end else if (v_s6) begin
			skv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skv_q) begin
			if (o_take) begin
				x_q <= skx_q;
				y_q <= sky_q;
				z_q <= skz_q;
			end
		end else if (!ov_q || o_take) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end else begin
			skx_q <= nx;
			sky_q <= ny;
			skz_q <= nz;
		end
	end

	assign result_valid = ov_q;
	assign x_out        = x_q;
	assign y_out        = y_q;
	assign z_out        = z_q;

	`S2C_ASSERT(a_skid_behind_out, skv_q |-> ov_q)
	`S2C_ASSERT_NEXT(a_frozen_tail, skv_q, $stable(v_s6) && $stable(v_s5))
	`S2C_ASSERT_NEXT(a_spill_to_skid, ov_q && result_stall && !skv_q && v_s6, skv_q)
	`S2C_ASSERT(a_out_range, result_valid |-> (x_out >= s2c_pkg::OUT_MIN && x_out <= s2c_pkg::OUT_MAX && y_out >= s2c_pkg::OUT_MIN && y_out <= s2c_pkg::OUT_MAX && z_out >= s2c_pkg::OUT_MIN && z_out <= s2c_pkg::OUT_MAX))

endmodule

`default_nettype wire

FILE: dv/tb_spherical_to_cartesian.sv
`timescale 1ns / 1ps
// Self-checking testbench for spherical_to_cartesian: a directed table, then random words.
// Depends on rtl/s2c_pkg.sv and the converter RTL; predicts untyped results with its CORDIC.
module tb_spherical_to_cartesian;

	localparam longint ANGLE_TURN    = 46080;
	localparam longint ANGLE_HALF    = 23040;
	localparam longint ANGLE_QUARTER = 11520;
	localparam longint START_GAIN    = 652032874;
	localparam int     MAX_STAGES    = 24;
	localparam int     USED_STAGES   = (s2c_pkg::CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES :
		s2c_pkg::CORDIC_STAGES;
	localparam int     LATENCY       = USED_STAGES + 6;
	localparam int     IDLE_LIMIT    = 2000;
	localparam int     RANDOM_WORDS  = 2000;
	localparam int     QUIET_WORDS   = 300;
	localparam int     N_DIRECTED    = 21;

	localparam longint ATAN_Q23 [MAX_STAGES] = '{
		377487360, 222843801, 117744544, 59768969,
		30000467, 15014858, 7509261, 3754860,
		1877459, 938733, 469367, 234683,
		117342, 58671, 29335, 14668,
		7334, 3667, 1833, 917,
		458, 229, 115, 57
	};

	typedef struct packed {
		logic [s2c_pkg::OUT_W-1:0] x;
		logic [s2c_pkg::OUT_W-1:0] y;
		logic [s2c_pkg::OUT_W-1:0] z;
	} vector_t;

	typedef struct packed {
		logic signed [s2c_pkg::RAD_W-1:0] radius;
		logic signed [s2c_pkg::ANG_W-1:0] incline;
		logic signed [s2c_pkg::ANG_W-1:0] azimuth;
		vector_t                          vec;
	} word_t;

	typedef struct packed {
		int radius;
		int incline;
		int azimuth;
		int typed;
		int wx;
		int wy;
		int wz;
	} table_row_t;

	// Rows with typed set carry a result that is exact by inspection; the rest are predicted.
	localparam table_row_t DIRECTED [N_DIRECTED] = '{
		'{0, 0, 0, 1, 0, 0, 0},
		'{0, -65536, 65535, 1, 0, 0, 0},
		'{0, 46080, -46080, 1, 0, 0, 0},
		'{32767, 0, 0, 0, 0, 0, 0},
		'{-32768, 0, 0, 0, 0, 0, 0},
		'{32767, 11520, 0, 0, 0, 0, 0},
		'{-32768, -11520, 0, 0, 0, 0, 0},
		'{32767, 0, 11520, 0, 0, 0, 0},
		'{32767, 0, -11520, 0, 0, 0, 0},
		'{-32768, 0, 23040, 0, 0, 0, 0},
		'{32767, 23040, -23040, 0, 0, 0, 0},
		'{32767, 46080, -46080, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0},
		'{-1, 11521, -11521, 0, 0, 0, 0},
		'{12345, 11519, 23041, 0, 0, 0, 0},
		'{32767, -23041, 34560, 0, 0, 0, 0},
		'{-32768, 65535, -65536, 0, 0, 0, 0},
		'{32767, -46079, 46079, 0, 0, 0, 0},
		'{20000, 5760, 5760, 0, 0, 0, 0},
		'{-20000, -5760, 17280, 0, 0, 0, 0},
		'{-32768, 46080, 0, 0, 0, 0, 0}
	};

	logic                              clk          = 1'b0;
	logic                              arst_n       = 1'b0;
	logic                              item_valid   = 1'b0;
	logic                              item_stall;
	logic signed [s2c_pkg::RAD_W-1:0]  radius       = '0;
	logic signed [s2c_pkg::ANG_W-1:0]  incline      = '0;
	logic signed [s2c_pkg::ANG_W-1:0]  azimuth      = '0;
	logic                              result_valid;
	logic                              result_stall = 1'b0;
	logic signed [s2c_pkg::OUT_W-1:0]  x_out;
	logic signed [s2c_pkg::OUT_W-1:0]  y_out;
	logic signed [s2c_pkg::OUT_W-1:0]  z_out;

	word_t   word_pending = '0;
	word_t   vectors_due[$];
	int      errors       = 0;
	int      idle_cycles  = 0;
	int      gap_pct      = 20;
	int      stall_pct    = 20;
	int      stall_left   = 0;
	bit      quiet        = 1'b0;

	spherical_to_cartesian dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.radius       (radius),
		.incline      (incline),
		.azimuth      (azimuth),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.x_out        (x_out),
		.y_out        (y_out),
		.z_out        (z_out)
	);

	always #5 clk = ~clk;

	function automatic longint round_near(input longint v, input int sh);
		longint half;
		half = longint'(1) << (sh - 1);
		if (v >= 0) begin
			return (v + half) >>> sh;
		end
		return -((-v + half) >>> sh);
	endfunction

	function automatic void cordic_sincos(input logic signed [s2c_pkg::ANG_W-1:0] ang,
			output longint c, output longint s);
		longint r;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		bit     flip;
		int     i;
		r = longint'(ang) % ANGLE_TURN;
		if (r < 0) begin
			r += ANGLE_TURN;
		end
		if (r > ANGLE_HALF) begin
			r -= ANGLE_TURN;
		end
		flip = 1'b0;
		if (r > ANGLE_QUARTER) begin
			r -= ANGLE_HALF;
			flip = 1'b1;
		end else if (r < -ANGLE_QUARTER) begin
			r += ANGLE_HALF;
			flip = 1'b1;
		end
		z = r * 65536;
		x = START_GAIN;
		y = 0;
		for (i = 0; i < USED_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_Q23[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_Q23[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic [s2c_pkg::OUT_W-1:0] scale_component(input longint rad,
			input longint f);
		longint v;
		v = round_near(rad * f, 30);
		if (v > 32768) begin
			v = 32768;
		end
		if (v < -32768) begin
			v = -32768;
		end
		return v[s2c_pkg::OUT_W-1:0];
	endfunction

	function automatic vector_t cartesian_of(input logic signed [s2c_pkg::RAD_W-1:0] rad,
			input logic signed [s2c_pkg::ANG_W-1:0] inc,
			input logic signed [s2c_pkg::ANG_W-1:0] azi);
		longint  ci;
		longint  si;
		longint  ca;
		longint  sa;
		vector_t v;
		cordic_sincos(inc, ci, si);
		cordic_sincos(azi, ca, sa);
		v.x = scale_component(longint'(rad), round_near(ci * ca, 30));
		v.y = scale_component(longint'(rad), round_near(ci * sa, 30));
		v.z = scale_component(longint'(rad), si);
		return v;
	endfunction

	function automatic logic signed [s2c_pkg::ANG_W-1:0] random_angle();
		int a;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: a = int'($urandom_range(0, 92160)) - 46080;
			6, 7: a = int'($urandom_range(0, 131071)) - 65536;
			default: a = (int'($urandom_range(0, 10)) - 5) * 11520 + int'($urandom_range(0, 4)) - 2;
		endcase
		return a[s2c_pkg::ANG_W-1:0];
	endfunction

	task automatic send_word(input word_t w);
		item_valid   <= 1'b1;
		radius       <= w.radius;
		incline      <= w.incline;
		azimuth      <= w.azimuth;
		word_pending <= w;
		do @(posedge clk); while (item_stall);
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (vectors_due.size() != 0);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0 && !quiet) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 16);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		word_t w;
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (item_valid && !item_stall) begin
				vectors_due.push_back(word_pending);
			end
			if (result_valid && !result_stall) begin
				if (vectors_due.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("Unexpected result word: x %0d y %0d z %0d", x_out, y_out, z_out);
					end
				end else begin
					w = vectors_due.pop_front();
					if (x_out !== w.vec.x || y_out !== w.vec.y || z_out !== w.vec.z) begin
						errors++;
						if (errors <= 10) begin
							$display("Wrong result for radius %0d incline %0d azimuth %0d:",
								w.radius, w.incline, w.azimuth);
							$display("  expected x %0d y %0d z %0d, got x %0d y %0d z %0d",
								$signed(w.vec.x), $signed(w.vec.y), $signed(w.vec.z),
								x_out, y_out, z_out);
						end
					end
				end
			end
		end
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		word_t      w;
		table_row_t row;
		int         i;
		int         pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED[i];
			w.radius  = 16'(row.radius);
			w.incline = 17'(row.incline);
			w.azimuth = 17'(row.azimuth);
			if (row.typed != 0) begin
				w.vec.x = 17'(row.wx);
				w.vec.y = 17'(row.wy);
				w.vec.z = 17'(row.wz);
			end else begin
				w.vec = cartesian_of(w.radius, w.incline, w.azimuth);
			end
			send_word(w);
		end
		drain_results();

		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 250 == 0) begin
				pick = $urandom_range(0, 2);
				gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 5 : 30;
				pick = $urandom_range(0, 2);
				stall_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 30;
			end
			if (i == RANDOM_WORDS / 2) begin
				drain_results();
			end
			if (i == RANDOM_WORDS - QUIET_WORDS) begin
				quiet = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: w.radius = 16'($urandom);
				4, 5: begin
					case ($urandom_range(0, 4))
						0: w.radius = -16'sd32768;
						1: w.radius = 16'sd32767;
						2: w.radius = 16'sd0;
						3: w.radius = 16'sd1;
						default: w.radius = -16'sd1;
					endcase
				end
				default: w.radius = 16'(int'($urandom_range(0, 2000)) - 1000);
			endcase
			w.incline = random_angle();
			w.azimuth = random_angle();
			w.vec = cartesian_of(w.radius, w.incline, w.azimuth);
			send_word(w);
		end

		drain_results();
		repeat (LATENCY + 8) @(posedge clk);
		if (errors == 0 && vectors_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/s2c_pkg.sv
rtl/spherical_to_cartesian.sv
dv/tb_spherical_to_cartesian.sv
